>>> src/skbs_pkg.sv
// shared types and constants for the sorted key binary search core
// no dependencies; imported by the channel interfaces and all modules
package skbs_pkg;

  localparam int KEY_W           = 32;
  localparam int SLOT_W          = 10;
  localparam int POS_W           = 10;
  localparam int COUNT_W         = 11;
  localparam int DEF_TABLE_DEPTH = 1024;

  // request codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // search sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PROBE = 4'b0010,
    ST_CMP   = 4'b0100,
    ST_DONE  = 4'b1000
  } skbs_state_t;

  // one search result
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } skbs_result_t;

endpackage

>>> src/skbs_if.sv
// valid/ready channel interfaces for requests and results
// depends on skbs_pkg for field widths
interface skbs_in_if import skbs_pkg::*;;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [SLOT_W-1:0] slot;
  logic [KEY_W-1:0]  key;

  modport source (output valid, input ready, output req_type, output slot, output key);
  modport sink   (input valid, output ready, input req_type, input slot, input key);
endinterface

interface skbs_out_if import skbs_pkg::*;;
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;

  modport source (output valid, input ready, output found, output position);
  modport sink   (input valid, output ready, input found, input position);
endinterface

>>> src/skbs_key_ram.sv
// key table: single write port, single registered read port
// depends on skbs_pkg for the key width
module skbs_key_ram import skbs_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int AW          = $clog2(DEF_TABLE_DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [KEY_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [KEY_W-1:0] rd_data
);

  logic [KEY_W-1:0] mem [TABLE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/skbs_search_ctrl.sv
// request handling, binary search sequencer and result register
// depends on skbs_pkg and skbs_if; drives the key table ports
module skbs_search_ctrl import skbs_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int AW          = $clog2(DEF_TABLE_DEPTH),
  parameter int CW          = $clog2(DEF_TABLE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  skbs_in_if.sink            in_ch,
  skbs_out_if.source         out_ch,
  input  logic [COUNT_W-1:0] entry_count,
  output logic               ram_wr_en,
  output logic [AW-1:0]      ram_wr_addr,
  output logic [KEY_W-1:0]   ram_wr_data,
  output logic               ram_rd_en,
  output logic [AW-1:0]      ram_rd_addr,
  input  logic [KEY_W-1:0]   ram_rd_data
);

  skbs_state_t      state_r, state_nxt;
  logic [CW-1:0]    low_r, low_nxt;
  logic [CW-1:0]    hi_ex_r, hi_ex_nxt;
  logic [AW-1:0]    mid_r, mid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  skbs_result_t     res_r, res_nxt;
  skbs_result_t     out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             in_acc;
  logic             slot_ok;
  logic [31:0]      count_wide;
  logic [CW-1:0]    count_sat;
  logic [CW:0]      mid_sum;
  logic [CW-1:0]    mid_full;
  logic             out_free;

  // handshake
  assign in_ch.ready     = (state_r == ST_IDLE);
  assign in_acc          = in_ch.valid && in_ch.ready;
  assign out_free        = !out_valid_r || out_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.found    = out_r.found;
  assign out_ch.position = out_r.position;

  // loads go straight to the table, out of range slots dropped
  assign slot_ok     = (32'(in_ch.slot) < 32'(TABLE_DEPTH));
  assign ram_wr_en   = in_acc && (in_ch.req_type == REQ_LOAD) && slot_ok;
  assign ram_wr_addr = AW'(in_ch.slot);
  assign ram_wr_data = in_ch.key;

  // entry count clipped to the table depth
  assign count_wide = (32'(entry_count) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                            : 32'(entry_count);
  assign count_sat  = count_wide[CW-1:0];

  // upper midpoint of [low, hi_ex)
  assign mid_sum  = {1'b0, low_r} + {1'b0, hi_ex_r};
  assign mid_full = mid_sum[CW:1];

  assign ram_rd_en   = (state_r == ST_PROBE) && (low_r < hi_ex_r);
  assign ram_rd_addr = mid_full[AW-1:0];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    low_nxt       = low_r;
    hi_ex_nxt     = hi_ex_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_ch.req_type == REQ_SEARCH)) begin
          key_nxt   = in_ch.key;
          low_nxt   = '0;
          hi_ex_nxt = count_sat;
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (low_r < hi_ex_r) begin
          mid_nxt   = mid_full[AW-1:0];
          state_nxt = ST_CMP;
        end else begin
          res_nxt   = '{found: 1'b0, position: '0};
          state_nxt = ST_DONE;
        end
      end
      ST_CMP: begin
        if (ram_rd_data < key_r) begin
          low_nxt   = CW'(mid_r) + CW'(1);
          state_nxt = ST_PROBE;
        end else if (ram_rd_data > key_r) begin
          hi_ex_nxt = CW'(mid_r);
          state_nxt = ST_PROBE;
        end else begin
          res_nxt   = '{found: 1'b1, position: POS_W'(mid_r)};
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    low_r   <= low_nxt;
    hi_ex_r <= hi_ex_nxt;
    mid_r   <= mid_nxt;
    key_r   <= key_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

`ifndef SYNTHESIS
  // a compare always follows a table read
  a_cmp_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> ($past(state_r) == ST_PROBE))
    else $error("compare without preceding probe");

  // probe stays inside the live range
  a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> ((CW'(mid_r) >= low_r) && (CW'(mid_r) < hi_ex_r)))
    else $error("probe outside search range");

  // a miss reports position zero
  a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.found) |-> (out_r.position == '0))
    else $error("miss with non-zero position");

  // finished result reaches the output register when it is free
  a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && out_free) |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("result not handed to output register");

  // no table write while a search is running
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> (state_r == ST_IDLE))
    else $error("table write during search");
`endif

endmodule

>>> src/sorted_key_binary_search_core.sv
// top level of the sorted key binary search core
// depends on skbs_pkg, skbs_if, skbs_key_ram and skbs_search_ctrl

// Keeps a table of TABLE_DEPTH 32-bit keys in one synchronous RAM and runs a
// binary search over the first entry_count slots (clipped to TABLE_DEPTH),
// probing the upper midpoint. A load transaction writes one key and leaves
// the core idle; slots at or above TABLE_DEPTH are dropped. A search
// transaction makes at most floor(log2(entry_count))+1 probes (11 for 1024
// entries); each probe is one RAM read plus one key compare. A hit ends at
// the compare that matches, a miss at the probe that finds the range empty;
// the result then moves into the output register once that register is free.
// The next transaction can be taken in the same cycle as the result appears.
// New transactions are taken once the previous search has moved its result
// into the output register, so a waiting result does not hold the input. The
// table is not cleared at reset: searches must only cover loaded slots.
module sorted_key_binary_search_core import skbs_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  skbs_in_if.sink            in_ch,
  skbs_out_if.source         out_ch,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [COUNT_W-1:0] entry_count_r;
  logic               ram_wr_en;
  logic [AW-1:0]      ram_wr_addr;
  logic [KEY_W-1:0]   ram_wr_data;
  logic               ram_rd_en;
  logic [AW-1:0]      ram_rd_addr;
  logic [KEY_W-1:0]   ram_rd_data;

  // entry count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_wr_en) begin
      entry_count_r <= cfg_wr_data;
    end
  end

  skbs_search_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .entry_count (entry_count_r),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  skbs_key_ram #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule
